// ===== rtl/core/tcc_pkg.sv =====
package tcc_pkg;

    localparam int CW   = 24;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;
    localparam int AL   = SQW / 2;
    localparam int AHW  = SQW - AL;
    localparam int PW   = DW + AHW + 1;
    localparam int NW   = DW + SQW;
    localparam int DDW  = 2 * DW + 2;
    localparam int QW   = NW + 1;
    localparam int VW   = NW + 2;
    localparam int OW   = 32;
    localparam int RW   = 2 * OW;
    localparam int SRW  = OW + 2;

    typedef struct packed {
        logic [DDW-1:0] rem;
        logic [NW-1:0]  num;
        logic [NW-1:0]  quo;
    } t_div_lane;

    typedef struct packed {
        logic signed [CW:0]   base_x;
        logic signed [CW:0]   base_y;
        logic signed [CW+1:0] h_rdx;
        logic                 hz;
        logic                 zd;
        logic                 nx_neg;
        logic                 ny_neg;
    } t_side;

    typedef struct packed {
        logic [RW-1:0]  val;
        logic [SRW-1:0] rem;
        logic [OW-1:0]  root;
    } t_sq;

    typedef struct packed {
        logic          zd;
        logic          big;
        logic          flag;
        logic [OW-1:0] cx;
        logic [OW-1:0] cy;
        logic [RW-1:0] rsq;
    } t_tail;

    function automatic t_div_lane div_step(input t_div_lane l, input logic [DDW-1:0] den);
        logic [DDW:0] sh;
        logic [DDW:0] df;
        logic         ge;
        t_div_lane    r;
        sh    = {l.rem, l.num[NW-1]};
        ge    = (sh >= {1'b0, den});
        df    = sh - {1'b0, den};
        r.rem = ge ? df[DDW-1:0] : sh[DDW-1:0];
        r.num = {l.num[NW-2:0], 1'b0};
        r.quo = {l.quo[NW-2:0], ge};
        return r;
    endfunction

    function automatic t_sq sq_step(input t_sq s);
        logic [SRW+1:0] sh;
        logic [SRW+1:0] trial;
        logic [SRW+1:0] df;
        logic           ge;
        t_sq            r;
        sh     = {s.rem, s.val[RW-1:RW-2]};
        trial  = {2'b00, s.root, 2'b01};
        ge     = (sh >= trial);
        df     = sh - trial;
        r.rem  = ge ? df[SRW-1:0] : sh[SRW-1:0];
        r.root = {s.root[OW-2:0], ge};
        r.val  = {s.val[RW-3:0], 2'b00};
        return r;
    endfunction

endpackage

// ===== rtl/core/tcc_div_cell.sv =====
module tcc_div_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [tcc_pkg::DDW-1:0]   i_den,
    input  tcc_pkg::t_div_lane        i_lx,
    input  tcc_pkg::t_div_lane        i_ly,
    input  tcc_pkg::t_side            i_side,
    output logic                      o_vld,
    output logic [tcc_pkg::DDW-1:0]   o_den,
    output tcc_pkg::t_div_lane        o_lx,
    output tcc_pkg::t_div_lane        o_ly,
    output tcc_pkg::t_side            o_side
);

    logic                    r_vld;
    logic [tcc_pkg::DDW-1:0] r_den;
    tcc_pkg::t_div_lane      r_lx;
    tcc_pkg::t_div_lane      r_ly;
    tcc_pkg::t_side          r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den  <= i_den;
        r_lx   <= tcc_pkg::div_step(i_lx, i_den);
        r_ly   <= tcc_pkg::div_step(i_ly, i_den);
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_den  = r_den;
    assign o_lx   = r_lx;
    assign o_ly   = r_ly;
    assign o_side = r_side;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_den != '0 |-> r_lx.rem < r_den && r_ly.rem < r_den)
        else $error("partial remainder not below divisor");

endmodule

// ===== rtl/core/tcc_sqrt_cell.sv =====
module tcc_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  tcc_pkg::t_sq   i_sq,
    input  tcc_pkg::t_tail i_tail,
    output logic           o_vld,
    output tcc_pkg::t_sq   o_sq,
    output tcc_pkg::t_tail o_tail
);

    logic           r_vld;
    tcc_pkg::t_sq   r_sq;
    tcc_pkg::t_tail r_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq   <= tcc_pkg::sq_step(i_sq);
        r_tail <= i_tail;
    end

    assign o_vld  = r_vld;
    assign o_sq   = r_sq;
    assign o_tail = r_tail;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_sq.rem <= {1'b0, r_sq.root, 1'b0})
        else $error("root remainder above twice the root");

endmodule

// ===== rtl/core/triangle_circumcircle.sv =====
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+---------------------------
// item in  | i_vert0_x .. i_vert2_y (24b signed)     | i_start while o_busy low
// item out | o_center_x/y, o_radius_sq/len, o_degen. | o_valid, one cycle strobe
//
// Fully pipelined: one item per cycle, through 7 front stages, one divider cell
// per numerator bit (75), 4 radius stages, 32 root cells and the output register.
// o_busy is never raised. Synchronous active-low reset clears the valid bits;
// data registers are not reset. Results cannot be stalled.
module triangle_circumcircle (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert0_x,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert0_y,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert1_x,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert1_y,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert2_x,
    input  logic signed [tcc_pkg::CW-1:0]  i_vert2_y,
    output logic                           o_valid,
    output logic signed [tcc_pkg::OW-1:0]  o_center_x,
    output logic signed [tcc_pkg::OW-1:0]  o_center_y,
    output logic [tcc_pkg::RW-1:0]         o_radius_sq,
    output logic [tcc_pkg::OW-1:0]         o_radius_len,
    output logic                           o_degenerate
);

    localparam int CW  = tcc_pkg::CW;
    localparam int DW  = tcc_pkg::DW;
    localparam int SQW = tcc_pkg::SQW;
    localparam int AL  = tcc_pkg::AL;
    localparam int PW  = tcc_pkg::PW;
    localparam int NW  = tcc_pkg::NW;
    localparam int DDW = tcc_pkg::DDW;
    localparam int QW  = tcc_pkg::QW;
    localparam int VW  = tcc_pkg::VW;
    localparam int OW  = tcc_pkg::OW;
    localparam int RW  = tcc_pkg::RW;

    function automatic logic [OW-1:0] sat_out(input logic signed [VW-1:0] v);
        logic fits;
        fits = (v[VW-1:OW-1] == '0) || (v[VW-1:OW-1] == '1);
        if (fits) begin
            return v[OW-1:0];
        end
        return v[VW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    endfunction

    function automatic logic sat_hit(input logic signed [VW-1:0] v);
        return !((v[VW-1:OW-1] == '0) || (v[VW-1:OW-1] == '1));
    endfunction

    assign o_busy = 1'b0;

    // stage 1: differences, horizontal case
    logic signed [CW-1:0] hx0, hx1;
    logic signed [CW:0]   hs, hc;
    logic                 hz;
    tcc_pkg::t_side       n1_side;

    always_comb begin
        hz = (i_vert0_y == i_vert1_y) && (i_vert1_y == i_vert2_y);
        if (i_vert0_x < i_vert1_x) begin
            hx0 = i_vert0_x;
            hx1 = (i_vert1_x < i_vert2_x) ? i_vert2_x : i_vert1_x;
        end else begin
            hx1 = i_vert1_x;
            hx0 = (i_vert2_x < i_vert0_x) ? i_vert2_x : i_vert0_x;
        end
        hs = (CW+1)'(hx0) + (CW+1)'(hx1);
        hc = (hs + $signed({{CW{1'b0}}, hs[CW]})) >>> 1;
        n1_side.base_x = hz ? hc : (CW+1)'(i_vert0_x);
        n1_side.base_y = (CW+1)'(i_vert0_y);
        n1_side.h_rdx  = (CW+2)'(hx0) - (CW+2)'(hc);
        n1_side.hz     = hz;
        n1_side.zd     = 1'b0;
        n1_side.nx_neg = 1'b0;
        n1_side.ny_neg = 1'b0;
    end

    logic [7:1]              r_vf;
    logic signed [DW-1:0]    r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [DW-1:0]    r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [DW-1:0]    r3_ax, r3_ay, r3_bx, r3_by;
    tcc_pkg::t_side          r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic [SQW-1:0]          r2_axx, r2_ayy, r2_bxx, r2_byy;
    logic signed [SQW-1:0]   r2_p1, r2_p2;
    logic [SQW-1:0]          r3_a, r3_b;
    logic signed [DDW-1:0]   r3_d, r4_d, r5_d, r6_d;
    logic signed [PW-1:0]    r4_bya_l, r4_bya_h, r4_ayb_l, r4_ayb_h;
    logic signed [PW-1:0]    r4_axb_l, r4_axb_h, r4_bxa_l, r4_bxa_h;
    logic signed [NW-1:0]    r5_bya, r5_ayb, r5_axb, r5_bxa;
    logic signed [NW-1:0]    r6_nx, r6_ny;
    logic [DDW-1:0]          r7_den;
    tcc_pkg::t_div_lane      r7_lx, r7_ly;
    tcc_pkg::t_side          r7_side;
    tcc_pkg::t_side          n7_side;

    always_comb begin
        n7_side        = r6_side;
        n7_side.zd     = (r6_d == '0) && !r6_side.hz;
        n7_side.nx_neg = r6_nx[NW-1] ^ r6_d[DDW-1];
        n7_side.ny_neg = r6_ny[NW-1] ^ r6_d[DDW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
        end else begin
            r_vf <= {r_vf[6:1], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax   <= DW'(i_vert1_x) - DW'(i_vert0_x);
        r1_ay   <= DW'(i_vert1_y) - DW'(i_vert0_y);
        r1_bx   <= DW'(i_vert2_x) - DW'(i_vert0_x);
        r1_by   <= DW'(i_vert2_y) - DW'(i_vert0_y);
        r1_side <= n1_side;

        r2_axx  <= r1_ax * r1_ax;
        r2_ayy  <= r1_ay * r1_ay;
        r2_bxx  <= r1_bx * r1_bx;
        r2_byy  <= r1_by * r1_by;
        r2_p1   <= r1_ax * r1_by;
        r2_p2   <= r1_ay * r1_bx;
        r2_ax   <= r1_ax;
        r2_ay   <= r1_ay;
        r2_bx   <= r1_bx;
        r2_by   <= r1_by;
        r2_side <= r1_side;

        r3_a    <= r2_axx + r2_ayy;
        r3_b    <= r2_bxx + r2_byy;
        r3_d    <= (DDW'(r2_p1) - DDW'(r2_p2)) <<< 1;
        r3_ax   <= r2_ax;
        r3_ay   <= r2_ay;
        r3_bx   <= r2_bx;
        r3_by   <= r2_by;
        r3_side <= r2_side;

        r4_bya_l <= r3_by * $signed({1'b0, r3_a[AL-1:0]});
        r4_bya_h <= r3_by * $signed({1'b0, r3_a[SQW-1:AL]});
        r4_ayb_l <= r3_ay * $signed({1'b0, r3_b[AL-1:0]});
        r4_ayb_h <= r3_ay * $signed({1'b0, r3_b[SQW-1:AL]});
        r4_axb_l <= r3_ax * $signed({1'b0, r3_b[AL-1:0]});
        r4_axb_h <= r3_ax * $signed({1'b0, r3_b[SQW-1:AL]});
        r4_bxa_l <= r3_bx * $signed({1'b0, r3_a[AL-1:0]});
        r4_bxa_h <= r3_bx * $signed({1'b0, r3_a[SQW-1:AL]});
        r4_d     <= r3_d;
        r4_side  <= r3_side;

        r5_bya  <= (NW'(r4_bya_h) <<< AL) + NW'(r4_bya_l);
        r5_ayb  <= (NW'(r4_ayb_h) <<< AL) + NW'(r4_ayb_l);
        r5_axb  <= (NW'(r4_axb_h) <<< AL) + NW'(r4_axb_l);
        r5_bxa  <= (NW'(r4_bxa_h) <<< AL) + NW'(r4_bxa_l);
        r5_d    <= r4_d;
        r5_side <= r4_side;

        r6_nx   <= r5_bya - r5_ayb;
        r6_ny   <= r5_axb - r5_bxa;
        r6_d    <= r5_d;
        r6_side <= r5_side;

        r7_den  <= r6_d[DDW-1] ? DDW'(-r6_d) : DDW'(r6_d);
        r7_lx   <= '{rem: '0, num: (r6_nx[NW-1] ? NW'(-r6_nx) : NW'(r6_nx)), quo: '0};
        r7_ly   <= '{rem: '0, num: (r6_ny[NW-1] ? NW'(-r6_ny) : NW'(r6_ny)), quo: '0};
        r7_side <= n7_side;
    end

    // divider chain, one quotient bit per cell
    logic                c_vld  [0:NW];
    logic [DDW-1:0]      c_den  [0:NW];
    tcc_pkg::t_div_lane  c_lx   [0:NW];
    tcc_pkg::t_div_lane  c_ly   [0:NW];
    tcc_pkg::t_side      c_side [0:NW];

    assign c_vld[0]  = r_vf[7];
    assign c_den[0]  = r7_den;
    assign c_lx[0]   = r7_lx;
    assign c_ly[0]   = r7_ly;
    assign c_side[0] = r7_side;

    for (genvar k = 0; k < NW; k++) begin : g_div
        tcc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (c_vld[k]),
            .i_den  (c_den[k]),
            .i_lx   (c_lx[k]),
            .i_ly   (c_ly[k]),
            .i_side (c_side[k]),
            .o_vld  (c_vld[k+1]),
            .o_den  (c_den[k+1]),
            .o_lx   (c_lx[k+1]),
            .o_ly   (c_ly[k+1]),
            .o_side (c_side[k+1])
        );
    end

    // center and radius
    tcc_pkg::t_side    dv;
    logic signed [QW-1:0] qx, qy;
    assign dv = c_side[NW];
    assign qx = dv.nx_neg ? -$signed({1'b0, c_lx[NW].quo}) : $signed({1'b0, c_lx[NW].quo});
    assign qy = dv.ny_neg ? -$signed({1'b0, c_ly[NW].quo}) : $signed({1'b0, c_ly[NW].quo});

    logic [4:1]           r_vp;
    logic signed [QW-1:0] r1p_rdx, r1p_rdy;
    logic signed [VW-1:0] r1p_cx, r1p_cy;
    logic [3:1]           r_zd;
    logic [QW-1:0]        mx, my;
    logic [OW-1:0]        r2p_mx, r2p_my;
    logic [OW-1:0]        r2p_cx, r2p_cy, r3p_cx, r3p_cy;
    logic                 r2p_flag, r2p_big, r3p_flag, r3p_big;
    logic [RW-1:0]        r3p_sx, r3p_sy;
    logic [RW:0]          r2sum, rs;
    logic                 bigx, ovf;
    tcc_pkg::t_tail       r4p_tail;
    tcc_pkg::t_sq         r4p_sq;

    assign mx    = r1p_rdx[QW-1] ? QW'(-r1p_rdx) : QW'(r1p_rdx);
    assign my    = r1p_rdy[QW-1] ? QW'(-r1p_rdy) : QW'(r1p_rdy);
    assign r2sum = (RW+1)'(r3p_sx) + (RW+1)'(r3p_sy);
    assign bigx  = r3p_big | r2sum[RW];
    assign rs    = (RW+1)'(r2sum[RW-1:0]) + (RW+1)'(r2sum[RW-1:20]);
    assign ovf   = rs[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[3:1], c_vld[NW]};
        end
    end

    always_ff @(posedge i_clk) begin
        r1p_rdx <= dv.hz ? QW'(dv.h_rdx) : qx;
        r1p_rdy <= dv.hz ? QW'(0) : qy;
        r1p_cx  <= VW'(dv.base_x) + (dv.hz ? VW'(0) : VW'(qx));
        r1p_cy  <= VW'(dv.base_y) + (dv.hz ? VW'(0) : VW'(qy));
        r_zd    <= {r_zd[2:1], dv.zd};

        r2p_cx   <= sat_out(r1p_cx);
        r2p_cy   <= sat_out(r1p_cy);
        r2p_flag <= sat_hit(r1p_cx) | sat_hit(r1p_cy);
        r2p_big  <= (mx[QW-1:OW] != '0) || (my[QW-1:OW] != '0);
        r2p_mx   <= mx[OW-1:0];
        r2p_my   <= my[OW-1:0];

        r3p_sx   <= r2p_mx * r2p_mx;
        r3p_sy   <= r2p_my * r2p_my;
        r3p_cx   <= r2p_cx;
        r3p_cy   <= r2p_cy;
        r3p_flag <= r2p_flag;
        r3p_big  <= r2p_big;

        r4p_tail <= '{zd:   r_zd[3],
                      big:  bigx,
                      flag: r3p_flag | bigx | ovf,
                      cx:   r3p_cx,
                      cy:   r3p_cy,
                      rsq:  ((bigx | ovf) ? {RW{1'b1}} : rs[RW-1:0])};
        r4p_sq   <= '{val: r2sum[RW-1:0], rem: '0, root: '0};
    end

    // root chain, one result bit per cell
    logic            s_vld  [0:OW];
    tcc_pkg::t_sq    s_sq   [0:OW];
    tcc_pkg::t_tail  s_tail [0:OW];

    assign s_vld[0]  = r_vp[4];
    assign s_sq[0]   = r4p_sq;
    assign s_tail[0] = r4p_tail;

    for (genvar k = 0; k < OW; k++) begin : g_sqrt
        tcc_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (s_vld[k]),
            .i_sq   (s_sq[k]),
            .i_tail (s_tail[k]),
            .o_vld  (s_vld[k+1]),
            .o_sq   (s_sq[k+1]),
            .o_tail (s_tail[k+1])
        );
    end

    tcc_pkg::t_tail tl;
    assign tl = s_tail[OW];

    logic                  r_ov;
    logic signed [OW-1:0]  r_ocx, r_ocy;
    logic [RW-1:0]         r_orsq;
    logic [OW-1:0]         r_olen;
    logic                  r_odeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= s_vld[OW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ocx  <= tl.zd ? {1'b0, {(OW-1){1'b1}}} : tl.cx;
        r_ocy  <= tl.zd ? {1'b0, {(OW-1){1'b1}}} : tl.cy;
        r_orsq <= tl.zd ? {RW{1'b1}} : tl.rsq;
        r_olen <= (tl.zd | tl.big) ? {OW{1'b1}} : s_sq[OW].root;
        r_odeg <= tl.zd | tl.flag;
    end

    assign o_valid      = r_ov;
    assign o_center_x   = r_ocx;
    assign o_center_y   = r_ocy;
    assign o_radius_sq  = r_orsq;
    assign o_radius_len = r_olen;
    assign o_degenerate = r_odeg;

    a_full_len_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_radius_len != {OW{1'b1}})
        else $error("saturated radius length without degenerate flag");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_radius_sq == '0 |-> o_radius_len == '0)
        else $error("nonzero length with zero squared radius");

endmodule

// ===== verif/circumcircle_checker.sv =====
`timescale 1ns / 100ps

module circumcircle_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [tcc_pkg::CW-1:0] i_vert0_x,
    input  logic signed [tcc_pkg::CW-1:0] i_vert0_y,
    input  logic signed [tcc_pkg::CW-1:0] i_vert1_x,
    input  logic signed [tcc_pkg::CW-1:0] i_vert1_y,
    input  logic signed [tcc_pkg::CW-1:0] i_vert2_x,
    input  logic signed [tcc_pkg::CW-1:0] i_vert2_y,
    input  logic                          i_valid,
    input  logic [tcc_pkg::OW-1:0]        i_center_x,
    input  logic [tcc_pkg::OW-1:0]        i_center_y,
    input  logic [tcc_pkg::RW-1:0]        i_radius_sq,
    input  logic [tcc_pkg::OW-1:0]        i_radius_len,
    input  logic                          i_degenerate,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [63:0] rsq;
        logic [31:0] rlen;
        logic        deg;
    } circle_t;

    circle_t circles_due[$];

    function automatic logic [31:0] clamp32(input wide_t v, inout logic flag);
        if (v > wide_t'(32'sh7FFF_FFFF)) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -wide_t'(64'sh8000_0000)) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] t;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (t * t <= n)
                root = t;
        end
        return root[31:0];
    endfunction

    function automatic circle_t circumcircle(input wide_t x0, input wide_t y0, input wide_t x1,
                                             input wide_t y1, input wide_t x2, input wide_t y2);
        circle_t c;
        wide_t ax, ay, bx, by, sa, sb, den, dx, dy, cx, cy, r2;
        logic [64:0] rs;
        logic flag;
        logic big;
        flag = 1'b0;
        if (y0 == y1 && y1 == y2) begin
            if (x0 < x1) begin
                if (x1 < x2)
                    x1 = x2;
            end else if (x2 < x0) begin
                x0 = x2;
            end
            cx = (x0 + x1) / 2;
            cy = y0;
            dx = x0 - cx;
            dy = 0;
        end else begin
            ax  = x1 - x0;
            ay  = y1 - y0;
            bx  = x2 - x0;
            by  = y2 - y0;
            sa  = ax * ax + ay * ay;
            sb  = bx * bx + by * by;
            den = 2 * (ax * by - ay * bx);
            if (den == 0) begin
                c.cx   = 32'h7FFF_FFFF;
                c.cy   = 32'h7FFF_FFFF;
                c.rsq  = '1;
                c.rlen = '1;
                c.deg  = 1'b1;
                return c;
            end
            dx = (by * sa - ay * sb) / den;
            dy = (ax * sb - bx * sa) / den;
            cx = x0 + dx;
            cy = y0 + dy;
        end
        c.cx = clamp32(cx, flag);
        c.cy = clamp32(cy, flag);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        big = dx >= (wide_t'(1) << 62) || dy >= (wide_t'(1) << 62);
        r2  = '0;
        if (!big) begin
            r2  = dx * dx + dy * dy;
            big = r2[127:64] != 0;
        end
        if (big) begin
            c.rsq  = '1;
            c.rlen = '1;
            flag   = 1'b1;
        end else begin
            rs = {1'b0, r2[63:0]} + {21'd0, r2[63:20]};
            if (rs[64]) begin
                c.rsq = '1;
                flag  = 1'b1;
            end else begin
                c.rsq = rs[63:0];
            end
            c.rlen = floor_root(r2[63:0]);
        end
        c.deg = flag;
        return c;
    endfunction

    always @(posedge i_clk) begin
        circle_t want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                circles_due = {circles_due, circumcircle(i_vert0_x, i_vert0_y, i_vert1_x,
                                                         i_vert1_y, i_vert2_x, i_vert2_y)};
            if (i_valid) begin
                if (circles_due.size() == 0) begin
                    $error("result with no item outstanding");
                    o_errors++;
                end else begin
                    want = circles_due.pop_front();
                    o_checked++;
                    if (i_center_x !== want.cx) begin
                        $error("center_x expected %h got %h", want.cx, i_center_x);
                        o_errors++;
                    end
                    if (i_center_y !== want.cy) begin
                        $error("center_y expected %h got %h", want.cy, i_center_y);
                        o_errors++;
                    end
                    if (i_radius_sq !== want.rsq) begin
                        $error("radius_sq expected %h got %h", want.rsq, i_radius_sq);
                        o_errors++;
                    end
                    if (i_radius_len !== want.rlen) begin
                        $error("radius_len expected %h got %h", want.rlen, i_radius_len);
                        o_errors++;
                    end
                    if (i_degenerate !== want.deg) begin
                        $error("degenerate expected %b got %b", want.deg, i_degenerate);
                        o_errors++;
                    end
                end
            end
            o_pending = circles_due.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CW = tcc_pkg::CW;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic signed [CW-1:0] i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y, i_vert2_x, i_vert2_y;
    logic o_valid;
    logic signed [tcc_pkg::OW-1:0] o_center_x, o_center_y;
    logic [tcc_pkg::RW-1:0] o_radius_sq;
    logic [tcc_pkg::OW-1:0] o_radius_len;
    logic o_degenerate;
    int errors, pending, checked;
    int n_sent;

    triangle_circumcircle dut (.*);

    circumcircle_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_vert0_x, .i_vert0_y, .i_vert1_x, .i_vert1_y, .i_vert2_x, .i_vert2_y,
        .i_valid(o_valid), .i_center_x(o_center_x), .i_center_y(o_center_y),
        .i_radius_sq(o_radius_sq), .i_radius_len(o_radius_len),
        .i_degenerate(o_degenerate),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic idle(input int n);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic random_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return;
        else if (r < 92)
            idle($urandom_range(1, 3));
        else
            idle($urandom_range(10, 60));
    endtask

    task automatic send_tri(input logic signed [CW-1:0] x0, y0, x1, y1, x2, y2);
        i_vert0_x <= x0;
        i_vert0_y <= y0;
        i_vert1_x <= x1;
        i_vert1_y <= y1;
        i_vert2_x <= x2;
        i_vert2_y <= y2;
        i_start   <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        n_sent++;
        @(negedge i_clk);
        random_idle();
    endtask

    function automatic logic signed [CW-1:0] near(input int c, input int span);
        return CW'(c + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    initial begin
        int kind, bx, by, ax, ay, k1, k2, span;
        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_vert0_x = '0;
        i_vert0_y = '0;
        i_vert1_x = '0;
        i_vert1_y = '0;
        i_vert2_x = '0;
        i_vert2_y = '0;
        n_sent    = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_tri(0, 0, 256, 0, 0, 256);
        send_tri(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_tri(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
        send_tri(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
        send_tri(100, 50, 300, 50, 700, 50);
        send_tri(100, 50, 300, 50, -700, 50);
        send_tri(300, 7, 100, 7, -40, 7);
        send_tri(300, 7, 100, 7, 900, 7);
        send_tri(CMIN, CMAX, CMAX, CMAX, 0, CMAX);
        send_tri(-5, -5, -5, -5, -5, -5);
        send_tri(0, 0, 100, 100, 300, 300);
        send_tri(10, 0, 10, 500, 10, -900);
        send_tri(1, 2, 1, 2, 40, 80);
        send_tri(CMIN, CMIN, CMAX, CMAX, 0, -1);
        send_tri(CMIN, 0, CMAX, 1, 0, 2);
        send_tri(0, 0, CMAX, 1, CMIN, 0);
        send_tri(1, 1, 2, 1, 1, 2);
        send_tri(-1, -1, -1, -1, 0, 0);
        send_tri(CMAX, 0, CMIN, 0, 0, CMAX);
        send_tri(-300, 20, 450, -70, 12, 999);

        idle(1);
        wait (pending == 0);
        @(negedge i_clk);

        for (int i = 0; i < 800; i++) begin
            if (i == 400) begin
                idle(1);
                wait (pending == 0);
                @(negedge i_clk);
            end
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 3) == 0) ? 4_000_000 : $urandom_range(2, 20000);
            bx = $signed($urandom_range(0, 6_000_000)) - 3_000_000;
            by = $signed($urandom_range(0, 6_000_000)) - 3_000_000;
            case (kind)
                0, 1: send_tri(CW'($urandom), CW'($urandom), CW'($urandom),
                               CW'($urandom), CW'($urandom), CW'($urandom));
                2: begin
                    by = $urandom;
                    send_tri(CW'($urandom), CW'(by), CW'($urandom), CW'(by),
                             CW'($urandom), CW'(by));
                end
                3: begin
                    ax = $signed($urandom_range(0, 2000)) - 1000;
                    ay = $signed($urandom_range(0, 2000)) - 1000;
                    k1 = $signed($urandom_range(0, 200)) - 100;
                    k2 = $signed($urandom_range(0, 200)) - 100;
                    send_tri(CW'(bx), CW'(by), CW'(bx + k1 * ax), CW'(by + k1 * ay),
                             CW'(bx + k2 * ax), CW'(by + k2 * ay));
                end
                default: send_tri(near(bx, span), near(by, span), near(bx, span),
                                  near(by, span), near(bx, span), near(by, span));
            endcase
        end

        idle(1);
        wait (pending == 0);
        repeat (130) @(posedge i_clk);
        $display("Sent %0d triangles (flat, collinear, extreme and random shapes);", n_sent);
        $display("compared %0d circumcircle results field by field.", checked);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
